// ===== src/bgs_pkg.sv =====
// ============================================================================
// bgs_pkg: shared constants and types of the bilinear grid sampler
// Field widths, register indexes, command codes and the axis stage controls.
// ============================================================================
package bgs_pkg;

    localparam int COORD_W   = 20;
    localparam int TOL_W     = 20;
    localparam int CELL_W    = 8;
    localparam int VALUE_W   = 16;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_DIM    = 256;
    localparam int DEF_VALUE_BITS = 16;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd1;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH_CELLS  = 1'b0,
        REG_HEIGHT_CELLS = 1'b1
    } reg_idx_t;

    // load enables of the three axis mapping stages
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
    } axis_adv_t;

endpackage

// ===== src/bgs_cfg_if.sv =====
// ============================================================================
// bgs_cfg_if: configuration write channel
// Carries a register index and write data under a valid/ready handshake.
// ============================================================================
interface bgs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bgs_pkg::CFG_IDX_W-1:0]  index;
    logic [bgs_pkg::CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/bgs_req_if.sv =====
// ============================================================================
// bgs_req_if: request channel of the grid sampler
// One request either writes a grid cell or samples the grid.
// ============================================================================
interface bgs_req_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [bgs_pkg::CELL_W-1:0]          cell_x;
    logic [bgs_pkg::CELL_W-1:0]          cell_y;
    logic [bgs_pkg::VALUE_W-1:0]         cell_value;
    logic signed [bgs_pkg::COORD_W-1:0]  coord_x;
    logic signed [bgs_pkg::COORD_W-1:0]  coord_y;
    logic [bgs_pkg::TOL_W-1:0]           tolerance;
    logic                                wrap_mode;

    modport source (output valid, output cmd, output cell_x, output cell_y,
                    output cell_value, output coord_x, output coord_y,
                    output tolerance, output wrap_mode, input ready);
    modport sink   (input valid, input cmd, input cell_x, input cell_y,
                    input cell_value, input coord_x, input coord_y,
                    input tolerance, input wrap_mode, output ready);
endinterface

// ===== src/bgs_res_if.sv =====
// ============================================================================
// bgs_res_if: result channel of the grid sampler
// One result per sample request.
// ============================================================================
interface bgs_res_if;
    logic                         valid;
    logic                         ready;
    logic [bgs_pkg::VALUE_W-1:0]  sample_value;
    logic                         sample_valid;

    modport source (output valid, output sample_value, output sample_valid, input ready);
    modport sink   (input valid, input sample_value, input sample_valid, output ready);
endinterface

// ===== src/bgs_axis_map.sv =====
// ============================================================================
// bgs_axis_map: three-stage mapping of one coordinate onto the grid
// Scales by the cell count, wraps or clamps the cell, and yields the cell,
// its neighbor on the sample's side and the interpolation weight.
// ============================================================================
module bgs_axis_map #(
    parameter int MAX_DIM   = bgs_pkg::DEF_MAX_DIM,
    parameter int FRAC_BITS = bgs_pkg::DEF_FRAC_BITS,
    localparam int NB = $clog2(MAX_DIM + 1),
    localparam int AB = $clog2(MAX_DIM)
) (
    input  logic                               clk,
    input  bgs_pkg::axis_adv_t                 adv,
    input  logic signed [bgs_pkg::COORD_W-1:0] coord,
    input  logic [bgs_pkg::TOL_W-1:0]          tol,
    input  logic                               wrap,
    input  logic [NB-1:0]                      cells,
    output logic [AB-1:0]                      k_near,
    output logic [AB-1:0]                      k_far,
    output logic [FRAC_BITS:0]                 t,
    output logic                               ok
);

    localparam int PW_A = bgs_pkg::COORD_W + NB + 1;
    localparam int PW_B = FRAC_BITS + NB + 2;
    localparam int PW   = (PW_A > PW_B) ? PW_A : PW_B;
    localparam int QW   = PW - FRAC_BITS;
    localparam int QB   = (FRAC_BITS < bgs_pkg::COORD_W) ? bgs_pkg::COORD_W - FRAC_BITS : 1;

    // stage A: position in cell units
    logic signed [PW-1:0]      pos_reg;
    logic [bgs_pkg::TOL_W-1:0] tol_reg;
    logic                      wrap_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv.load_a)
        begin
            pos_reg    <= $signed(PW'(coord)) * $signed(PW'(cells));
            tol_reg    <= tol;
            wrap_a_reg <= wrap;
        end
    end

    // stage B: magnitude, whole cells, remainder modulo the cell count
    logic                 neg;
    logic [PW-1:0]        mag;
    logic [QW-1:0]        q;
    logic [QW-1:0]        n_q;
    logic [QW-1:0]        rem;
    logic [PW-1:0]        n_s;

    always_comb
    begin
        neg = pos_reg[PW-1];
        mag = neg ? PW'(-pos_reg) : PW'(pos_reg);
        q   = mag[PW-1:FRAC_BITS];
        n_q = QW'(cells);
        n_s = PW'(cells) << FRAC_BITS;
        rem = q;
        for (int b = QB - 1; b >= 0; b--)
        begin
            if (rem >= (n_q << b))
                rem = rem - (n_q << b);
        end
    end

    logic                 neg_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic                 q_nz_reg;
    logic                 above_reg;
    logic [NB-1:0]        rem_reg;
    logic                 below_ok_reg;
    logic                 above_ok_reg;
    logic                 wrap_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv.load_b)
        begin
            neg_reg      <= neg;
            frac_reg     <= mag[FRAC_BITS-1:0];
            q_nz_reg     <= |q;
            above_reg    <= !neg && (q >= n_q);
            rem_reg      <= NB'(rem);
            below_ok_reg <= mag < PW'(tol_reg);
            above_ok_reg <= (mag - n_s) < PW'(tol_reg);
            wrap_b_reg   <= wrap_a_reg;
        end
    end

    // stage C: final cell, offset from its center, neighbor
    logic [NB-1:0]               k;
    logic signed [FRAC_BITS+1:0] e;
    logic signed [FRAC_BITS+1:0] d;
    logic                        ok_c;
    logic                        side;
    logic                        has_nb;
    logic [NB-1:0]               nb;

    always_comb
    begin
        k    = (neg_reg && (rem_reg != '0)) ? cells - rem_reg : rem_reg;
        e    = neg_reg ? -$signed({2'b00, frac_reg}) : $signed({2'b00, frac_reg});
        ok_c = 1'b1;
        if (!wrap_b_reg && neg_reg && q_nz_reg)
        begin
            k    = '0;
            e    = '0;
            ok_c = below_ok_reg;
        end
        else if (!wrap_b_reg && above_reg)
        begin
            k    = cells - NB'(1);
            e    = $signed({2'b01, {FRAC_BITS{1'b0}}});
            ok_c = above_ok_reg;
        end
        d    = e - $signed({3'b001, {(FRAC_BITS-1){1'b0}}});
        side = !d[FRAC_BITS+1] && (d != '0);
        if (side)
        begin
            if (k == cells - NB'(1))
            begin
                has_nb = wrap_b_reg;
                nb     = '0;
            end
            else
            begin
                has_nb = 1'b1;
                nb     = k + NB'(1);
            end
        end
        else
        begin
            if (k == '0)
            begin
                has_nb = wrap_b_reg;
                nb     = cells - NB'(1);
            end
            else
            begin
                has_nb = 1'b1;
                nb     = k - NB'(1);
            end
        end
    end

    logic [AB-1:0]      k1_reg;
    logic [AB-1:0]      k2_reg;
    logic [FRAC_BITS:0] t_reg;
    logic               ok_reg;

    always_ff @(posedge clk)
    begin
        if (adv.load_c)
        begin
            k1_reg <= AB'(k);
            // a missing neighbor reads the cell itself, which turns the lerp along this axis into a copy
            k2_reg <= has_nb ? AB'(nb) : AB'(k);
            t_reg  <= side ? (FRAC_BITS+1)'(d) : (FRAC_BITS+1)'(-d);
            ok_reg <= ok_c;
        end
    end

    assign k_near = k1_reg;
    assign k_far  = k2_reg;
    assign t      = t_reg;
    assign ok     = ok_reg;

endmodule

// ===== src/bilinear_grid_sampler.sv =====
// ============================================================================
// bilinear_grid_sampler: stored 2D grid with wrap/clamp bilinear sampling
// Cell writes and sample requests share one pipelined request channel.
// ============================================================================
//  channel | role   | carries
//  cfg     | sink   | index, data (width_cells, height_cells)
//  req     | sink   | cmd, cell_x/y, cell_value, coord_x/y, tolerance, wrap_mode
//  res     | source | sample_value, sample_valid (one per sample request)
//
// One request per cycle while results are taken; a sample result is offered from the
// stage 8 result register. A write lands in the grid as it leaves stage 3, in request order.
// The rate comes from four copies of the grid, one read port each, so the
// four neighbors of a sample are read in the same cycle.
// Reset clears the pipeline valid bits and sets the cell counts to one; the grid is not cleared.
// A stalled result holds the filled stages; empty stages behind it keep moving up.
module bilinear_grid_sampler #(
    parameter int MAX_DIM    = bgs_pkg::DEF_MAX_DIM,
    parameter int VALUE_BITS = bgs_pkg::DEF_VALUE_BITS,
    parameter int FRAC_BITS  = bgs_pkg::DEF_FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    bgs_cfg_if.sink    cfg,
    bgs_req_if.sink    req,
    bgs_res_if.source  res
);

    localparam int NB    = $clog2(MAX_DIM + 1);
    localparam int AB    = $clog2(MAX_DIM);
    localparam int DEPTH = 1 << (2 * AB);
    localparam int VB    = VALUE_BITS;
    localparam int DW    = VB + 1;
    localparam int PAW   = VB + FRAC_BITS + 2;
    localparam int AW    = VB + 2;
    localparam int BDW   = VB + 3;
    localparam int PMW   = VB + FRAC_BITS + 4;
    localparam int RW    = VB + FRAC_BITS + 5;
    localparam logic signed [PAW-1:0] HALF_A = PAW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [RW-1:0]  HALF_R = RW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [RW-1:0]  VMAX_R = (RW'(1) <<< VB) - RW'(1);

    // configuration
    logic [bgs_pkg::CFG_W-1:0] width_reg;
    logic [bgs_pkg::CFG_W-1:0] height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bgs_pkg::CFG_RESET;
            height_reg <= bgs_pkg::CFG_RESET;
        end
        else if (cfg.valid)
        begin
            case (bgs_pkg::reg_idx_t'(cfg.index))
                bgs_pkg::REG_WIDTH_CELLS:  width_reg  <= cfg.data;
                bgs_pkg::REG_HEIGHT_CELLS: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    logic [NB-1:0] nx;
    logic [NB-1:0] ny;

    always_comb
    begin
        if (width_reg == '0)
            nx = NB'(1);
        else if (32'(width_reg) > MAX_DIM)
            nx = NB'(MAX_DIM);
        else
            nx = NB'(width_reg);
        if (height_reg == '0)
            ny = NB'(1);
        else if (32'(height_reg) > MAX_DIM)
            ny = NB'(MAX_DIM);
        else
            ny = NB'(height_reg);
    end

    // pipeline flow control
    logic [8:1] vld_reg;
    logic [8:1] adv;

    always_comb
    begin
        adv[8] = !vld_reg[8] || res.ready;
        for (int s = 7; s >= 1; s--)
            adv[s] = !vld_reg[s] || adv[s+1];
    end

    assign req.ready = adv[1];

    logic cmd3_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[1]) vld_reg[1] <= req.valid;
            if (adv[2]) vld_reg[2] <= vld_reg[1];
            if (adv[3]) vld_reg[3] <= vld_reg[2];
            // drop write requests once they reach the grid
            if (adv[4]) vld_reg[4] <= vld_reg[3] && cmd3_sample;
            if (adv[5]) vld_reg[5] <= vld_reg[4];
            if (adv[6]) vld_reg[6] <= vld_reg[5];
            if (adv[7]) vld_reg[7] <= vld_reg[6];
            if (adv[8]) vld_reg[8] <= vld_reg[7];
        end
    end

    // stages 1..3: request fields beside the axis mapping
    logic                       cmd_reg   [1:3];
    logic [bgs_pkg::CELL_W-1:0] x_reg     [1:3];
    logic [bgs_pkg::CELL_W-1:0] y_reg     [1:3];
    logic [VB-1:0]              val_reg   [1:3];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            cmd_reg[1] <= req.cmd;
            x_reg[1]   <= req.cell_x;
            y_reg[1]   <= req.cell_y;
            val_reg[1] <= VB'(req.cell_value);
        end
        if (adv[2])
        begin
            cmd_reg[2] <= cmd_reg[1];
            x_reg[2]   <= x_reg[1];
            y_reg[2]   <= y_reg[1];
            val_reg[2] <= val_reg[1];
        end
        if (adv[3])
        begin
            cmd_reg[3] <= cmd_reg[2];
            x_reg[3]   <= x_reg[2];
            y_reg[3]   <= y_reg[2];
            val_reg[3] <= val_reg[2];
        end
    end

    assign cmd3_sample = (cmd_reg[3] == bgs_pkg::CMD_SAMPLE);

    bgs_pkg::axis_adv_t axis_adv;
    logic [AB-1:0]      i1, i2, j1, j4;
    logic [FRAC_BITS:0] tx, ty;
    logic               okx, oky;

    assign axis_adv = '{load_a: adv[1], load_b: adv[2], load_c: adv[3]};

    bgs_axis_map #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_axis_x (
        .clk    (clk),
        .adv    (axis_adv),
        .coord  (req.coord_x),
        .tol    (req.tolerance),
        .wrap   (req.wrap_mode),
        .cells  (nx),
        .k_near (i1),
        .k_far  (i2),
        .t      (tx),
        .ok     (okx)
    );

    bgs_axis_map #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_axis_y (
        .clk    (clk),
        .adv    (axis_adv),
        .coord  (req.coord_y),
        .tol    (req.tolerance),
        .wrap   (req.wrap_mode),
        .cells  (ny),
        .k_near (j1),
        .k_far  (j4),
        .t      (ty),
        .ok     (oky)
    );

    // grid: four identical copies, written together, read at the four corners
    logic              we;
    logic [2*AB-1:0]   waddr;
    logic [2*AB-1:0]   raddr [4];
    logic [VB-1:0]     rd_reg [4];

    assign we = vld_reg[3] && !cmd3_sample && adv[4]
                && (32'(x_reg[3]) < MAX_DIM) && (32'(y_reg[3]) < MAX_DIM);
    assign waddr    = {AB'(x_reg[3]), AB'(y_reg[3])};
    assign raddr[0] = {i1, j1};
    assign raddr[1] = {i2, j1};
    assign raddr[2] = {i1, j4};
    assign raddr[3] = {i2, j4};

    for (genvar c = 0; c < 4; c++)
    begin : g_copy
        logic [VB-1:0] mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (we)
                mem[waddr] <= val_reg[3];
            if (adv[4])
                rd_reg[c] <= mem[raddr[c]];
        end
    end

    logic [FRAC_BITS:0] tx4_reg, ty4_reg;
    logic               ok4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            tx4_reg <= tx;
            ty4_reg <= ty;
            ok4_reg <= okx && oky;
        end
    end

    // stage 5: x-axis products for both rows
    logic signed [DW-1:0]  dif_a, dif_b;
    logic signed [PAW-1:0] pa5_reg, pb5_reg;
    logic [VB-1:0]         v1_5_reg, v4_5_reg;
    logic [FRAC_BITS:0]    ty5_reg;
    logic                  ok5_reg;

    assign dif_a = $signed({1'b0, rd_reg[1]}) - $signed({1'b0, rd_reg[0]});
    assign dif_b = $signed({1'b0, rd_reg[3]}) - $signed({1'b0, rd_reg[2]});

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            pa5_reg  <= PAW'(dif_a) * $signed(PAW'(tx4_reg));
            pb5_reg  <= PAW'(dif_b) * $signed(PAW'(tx4_reg));
            v1_5_reg <= rd_reg[0];
            v4_5_reg <= rd_reg[2];
            ty5_reg  <= ty4_reg;
            ok5_reg  <= ok4_reg;
        end
    end

    // stage 6: row values
    logic signed [PAW-1:0] row_a, row_b;
    logic signed [AW-1:0]  a6_reg, b6_reg;
    logic [FRAC_BITS:0]    ty6_reg;
    logic                  ok6_reg;

    assign row_a = ((pa5_reg + HALF_A) >>> FRAC_BITS) + $signed(PAW'(v1_5_reg));
    assign row_b = ((pb5_reg + HALF_A) >>> FRAC_BITS) + $signed(PAW'(v4_5_reg));

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            a6_reg  <= AW'(row_a);
            b6_reg  <= AW'(row_b);
            ty6_reg <= ty5_reg;
            ok6_reg <= ok5_reg;
        end
    end

    // stage 7: y-axis product
    logic signed [BDW-1:0] dif_y;
    logic signed [PMW-1:0] pm7_reg;
    logic signed [AW-1:0]  a7_reg;
    logic                  ok7_reg;

    assign dif_y = BDW'(b6_reg) - BDW'(a6_reg);

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            pm7_reg <= PMW'(dif_y) * $signed(PMW'(ty6_reg));
            a7_reg  <= a6_reg;
            ok7_reg <= ok6_reg;
        end
    end

    // stage 8: round, saturate, result register
    logic signed [RW-1:0]        r_full;
    logic [VB-1:0]               r_sat;
    logic [bgs_pkg::VALUE_W-1:0] value_reg;
    logic                        svalid_reg;

    always_comb
    begin
        r_full = ((RW'(pm7_reg) + HALF_R) >>> FRAC_BITS) + RW'(a7_reg);
        if (r_full < 0)
            r_sat = '0;
        else if (r_full > VMAX_R)
            r_sat = VB'(VMAX_R);
        else
            r_sat = VB'(r_full);
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            value_reg  <= ok7_reg ? bgs_pkg::VALUE_W'(r_sat) : '0;
            svalid_reg <= ok7_reg;
        end
    end

    assign res.valid        = vld_reg[8];
    assign res.sample_value = value_reg;
    assign res.sample_valid = svalid_reg;

    a_write_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && !cmd3_sample && adv[4]) |=> !vld_reg[4])
        else $error("write request passed the grid stage");

    a_sample_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && cmd3_sample && adv[4]) |=> vld_reg[4])
        else $error("sample request lost at the grid stage");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[7] && adv[8]) |=> res.valid)
        else $error("finished sample did not reach the result register");

endmodule
